// ===== src/packed_sample_power_agc_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packed sample power AGC
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PACKED_SAMPLE_POWER_AGC_ASSERT_SVH
`define PACKED_SAMPLE_POWER_AGC_ASSERT_SVH

// Same-cycle implication.
`define PSAGC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psagc assertion failed");

// Next-cycle implication.
`define PSAGC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psagc assertion failed");

`endif

// ===== src/psagc_pkg.sv =====
// ----------------------------------------------------------------------------
// Packed sample power AGC package
// Shared types, constants, sample squaring and gain table lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package psagc_pkg;

    localparam int SAMPLE_W       = 12;
    localparam int SQ_W           = 23;
    localparam int THRESH_W       = 26;
    localparam int CFG_DATA_W     = 26;
    localparam int CFG_INDEX_W    = 2;
    localparam int STEP_W         = 5;
    localparam int CODE_W         = 4;
    localparam int HOLD_W         = 2;
    localparam int ENERGY_SHIFT   = 21;
    localparam int THRESH_FRAC    = 24;
    localparam int GROUP_SAMPLES  = 8;
    localparam int STEP_COUNT     = 22;

    localparam logic [STEP_W-1:0]     STEP_MAX       = 5'd21;
    localparam logic [HOLD_W-1:0]     HOLDOFF_RELOAD = 2'd2;
    localparam logic [THRESH_W-1:0]   LOW_THRESH_RST  = 26'd1678;
    localparam logic [THRESH_W-1:0]   HIGH_THRESH_RST = 26'd1677722;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_AGC_ENABLE  = 2'd0,
        REG_LINEARITY   = 2'd1,
        REG_LOW_THRESH  = 2'd2,
        REG_HIGH_THRESH = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_RAISE = 2'd1,
        ACT_LOWER = 2'd2,
        ACT_HOLD  = 2'd3
    } action_t;

    typedef struct packed {
        logic [CODE_W-1:0] lna;
        logic [CODE_W-1:0] mixer;
        logic [CODE_W-1:0] vga;
    } gain_codes_t;

    typedef struct packed {
        logic [STEP_W-1:0] gain_step;
        gain_codes_t       codes;
        action_t           action;
        logic              gain_changed;
    } result_t;

    // Tables are indexed by (STEP_MAX - step).
    localparam logic [CODE_W-1:0] LIN_VGA [0:STEP_COUNT-1] = '{
        4'd13, 4'd12, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd10, 4'd10, 4'd10, 4'd10,
        4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4};
    localparam logic [CODE_W-1:0] LIN_MIX [0:STEP_COUNT-1] = '{
        4'd12, 4'd12, 4'd11, 4'd9, 4'd8, 4'd7, 4'd6, 4'd6, 4'd5, 4'd0, 4'd0,
        4'd1, 4'd0, 4'd0, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd0};
    localparam logic [CODE_W-1:0] LIN_LNA [0:STEP_COUNT-1] = '{
        4'd14, 4'd14, 4'd14, 4'd13, 4'd12, 4'd10, 4'd9, 4'd9, 4'd8, 4'd9, 4'd8,
        4'd6, 4'd5, 4'd3, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
    localparam logic [CODE_W-1:0] SEN_VGA [0:STEP_COUNT-1] = '{
        4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd5, 4'd5,
        4'd5, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4};
    localparam logic [CODE_W-1:0] SEN_MIX [0:STEP_COUNT-1] = '{
        4'd12, 4'd12, 4'd12, 4'd12, 4'd11, 4'd10, 4'd10, 4'd9, 4'd9, 4'd8, 4'd7,
        4'd4, 4'd4, 4'd4, 4'd3, 4'd2, 4'd2, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0};
    localparam logic [CODE_W-1:0] SEN_LNA [0:STEP_COUNT-1] = '{
        4'd14, 4'd14, 4'd14, 4'd14, 4'd14, 4'd14, 4'd14, 4'd14, 4'd14, 4'd13, 4'd12,
        4'd12, 4'd9, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd3, 4'd2, 4'd1, 4'd0};

    // Offset-binary sample to two's complement is an inversion of the MSB.
    function automatic logic [SQ_W-1:0] sample_square(input logic [SAMPLE_W-1:0] raw);
        logic signed [SAMPLE_W-1:0]   x;
        logic signed [2*SAMPLE_W-1:0] p;
        x = {~raw[SAMPLE_W-1], raw[SAMPLE_W-2:0]};
        p = x * x;
        return p[SQ_W-1:0];
    endfunction

    function automatic gain_codes_t gain_lookup(input logic [STEP_W-1:0] step,
                                                input logic              lin);
        logic [STEP_W-1:0] tab;
        gain_codes_t       codes;
        tab = STEP_MAX - step;
        if (lin)
        begin
            codes.lna   = LIN_LNA[tab];
            codes.mixer = LIN_MIX[tab];
            codes.vga   = LIN_VGA[tab];
        end
        else
        begin
            codes.lna   = SEN_LNA[tab];
            codes.mixer = SEN_MIX[tab];
            codes.vga   = SEN_VGA[tab];
        end
        return codes;
    endfunction

endpackage

`default_nettype wire

// ===== src/psagc_fifo.sv =====
// ----------------------------------------------------------------------------
// Packed sample power AGC queue
// Small first-word-fall-through queue with an occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packed_sample_power_agc_assert.svh"

module psagc_fifo import psagc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW   = $clog2(DEPTH),
    localparam int LW   = $clog2(DEPTH + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic                  empty,
    output logic      [WIDTH-1:0] rd_data,
    output logic      [LW-1:0]    level
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [LW-1:0]    level_reg;
    logic [LW-1:0]    level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign empty   = (level_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign level   = level_reg;

    `PSAGC_ASSERT_NOW(a_no_overflow, wr_en && !rd_en, level_reg < LW'(DEPTH))
    `PSAGC_ASSERT_NOW(a_no_underflow, rd_en, level_reg != '0)
    `PSAGC_ASSERT_NOW(a_level_bound, 1'b1, level_reg <= LW'(DEPTH))

endmodule

`default_nettype wire

// ===== src/psagc_front.sv =====
// ----------------------------------------------------------------------------
// Packed sample power AGC front end
// Unpacks 12-bit samples, squares them and accumulates transfer energy.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packed_sample_power_agc_assert.svh"

module psagc_front import psagc_pkg::*;
#(
    parameter int MAX_SAMPLES = 1048576,
    parameter int Q_DEPTH     = 4,
    localparam int CNT_W      = $clog2(MAX_SAMPLES + 1),
    localparam int ENERGY_W   = CNT_W + SQ_W - 1,
    localparam int LVL_W      = $clog2(Q_DEPTH + 1)
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [31:0]         packed_word,
    input  wire logic                last_word,
    input  wire logic [LVL_W-1:0]    q_level,
    output logic                     req_push,
    output logic      [ENERGY_W-1:0] req_energy,
    output logic      [CNT_W-1:0]    req_count
);

    localparam int SUM3_W = SQ_W + 1;
    localparam int GRP_W  = SQ_W + 3;

    typedef enum logic [2:0] {
        PH_0 = 3'b001,
        PH_1 = 3'b010,
        PH_2 = 3'b100
    } phase_t;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [7:0]          partial_reg;
    logic [7:0]          partial_next;
    logic                accept;
    logic [SAMPLE_W-1:0] smp0;
    logic [SAMPLE_W-1:0] smp1;
    logic [SAMPLE_W-1:0] smp2;
    logic                use2;
    logic                grp_end;
    logic [SUM3_W-1:0]   sum3;

    logic                s1_valid_reg;
    logic [SUM3_W-1:0]   s1_sum_reg;
    logic                s1_end_reg;
    logic                s1_last_reg;

    logic [GRP_W-1:0]    group_reg;
    logic [GRP_W-1:0]    group_next;
    logic [ENERGY_W-1:0] energy_reg;
    logic [ENERGY_W-1:0] energy_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [GRP_W-1:0]    group_sum;
    logic                commit_ok;
    logic [LVL_W:0]      pending;

    // A last word in the square stage already owns a queue slot.
    assign pending = {1'b0, q_level} + (LVL_W + 1)'(s1_valid_reg & s1_last_reg);
    assign full    = (pending >= (LVL_W + 1)'(Q_DEPTH));
    assign accept  = push && !full;

    always_comb
    begin
        smp0         = '0;
        smp1         = '0;
        smp2         = '0;
        use2         = 1'b0;
        grp_end      = 1'b0;
        phase_next   = phase_reg;
        partial_next = partial_reg;
        unique case (phase_reg)
            PH_0:
            begin
                smp0         = packed_word[31:20];
                smp1         = packed_word[19:8];
                partial_next = packed_word[7:0];
                phase_next   = PH_1;
            end
            PH_1:
            begin
                smp0         = {partial_reg, packed_word[31:28]};
                smp1         = packed_word[27:16];
                smp2         = packed_word[15:4];
                use2         = 1'b1;
                partial_next = {4'b0000, packed_word[3:0]};
                phase_next   = PH_2;
            end
            PH_2:
            begin
                smp0         = {partial_reg[3:0], packed_word[31:24]};
                smp1         = packed_word[23:12];
                smp2         = packed_word[11:0];
                use2         = 1'b1;
                grp_end      = 1'b1;
                partial_next = '0;
                phase_next   = PH_0;
            end
            default:
            begin
                phase_next   = PH_0;
            end
        endcase
        if (last_word)
        begin
            partial_next = '0;
            phase_next   = PH_0;
        end
    end

    assign sum3 = SUM3_W'(sample_square(smp0)) + SUM3_W'(sample_square(smp1))
                + (use2 ? SUM3_W'(sample_square(smp2)) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_0;
            partial_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s1_end_reg   <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                phase_reg   <= phase_next;
                partial_reg <= partial_next;
                s1_end_reg  <= grp_end;
                s1_last_reg <= last_word;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sum_reg <= sum3;
        end
    end

    assign group_sum = group_reg + GRP_W'(s1_sum_reg);
    assign commit_ok = ({1'b0, count_reg} + (CNT_W + 1)'(GROUP_SAMPLES))
                       <= (CNT_W + 1)'(MAX_SAMPLES);

    always_comb
    begin
        group_next  = group_reg;
        energy_next = energy_reg;
        count_next  = count_reg;
        if (s1_valid_reg)
        begin
            if (s1_end_reg)
            begin
                group_next = '0;
                if (commit_ok)
                begin
                    energy_next = energy_reg + ENERGY_W'(group_sum);
                    count_next  = count_reg + CNT_W'(GROUP_SAMPLES);
                end
            end
            else
            begin
                group_next = group_sum;
            end
        end
    end

    assign req_push   = s1_valid_reg && s1_last_reg;
    assign req_energy = energy_next;
    assign req_count  = count_next;

    // Partial groups are dropped and the totals clear after every transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg  <= '0;
            energy_reg <= '0;
            count_reg  <= '0;
        end
        else if (req_push)
        begin
            group_reg  <= '0;
            energy_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            group_reg  <= group_next;
            energy_reg <= energy_next;
            count_reg  <= count_next;
        end
    end

    `PSAGC_ASSERT_NEXT(a_last_resets_phase, accept && last_word, phase_reg == PH_0)
    `PSAGC_ASSERT_NEXT(a_last_clears_totals, req_push,
        group_reg == '0 && energy_reg == '0 && count_reg == '0)
    `PSAGC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_SAMPLES))

endmodule

`default_nettype wire

// ===== src/psagc_back.sv =====
// ----------------------------------------------------------------------------
// Packed sample power AGC back end
// Threshold compare, gain step decision, holdoff and gain table lookup.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packed_sample_power_agc_assert.svh"

module psagc_back import psagc_pkg::*;
#(
    parameter int MAX_SAMPLES = 1048576,
    parameter int RES_DEPTH   = 2,
    localparam int CNT_W      = $clog2(MAX_SAMPLES + 1),
    localparam int ENERGY_W   = CNT_W + SQ_W - 1,
    localparam int RLVL_W     = $clog2(RES_DEPTH + 1)
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   req_empty,
    input  wire logic [ENERGY_W-1:0]    req_energy,
    input  wire logic [CNT_W-1:0]       req_count,
    output logic                        req_pop,
    input  wire logic [RLVL_W-1:0]      res_level,
    output logic                        res_push,
    output result_t                     res_data
);

    localparam int PROD_W = THRESH_W + CNT_W;

    logic                agc_enable_reg;
    logic                linearity_reg;
    logic [THRESH_W-1:0] low_thresh_reg;
    logic [THRESH_W-1:0] high_thresh_reg;

    logic                b1_valid_reg;
    logic [PROD_W-1:0]   b1_lhs_reg;
    logic [PROD_W-1:0]   b1_plo_reg;
    logic [PROD_W-1:0]   b1_phi_reg;
    logic                b1_nz_reg;

    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [HOLD_W-1:0]   hold_reg;
    logic [HOLD_W-1:0]   hold_next;
    action_t             act;
    logic                below;
    logic                above;
    logic [RLVL_W:0]     res_pending;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agc_enable_reg  <= 1'b1;
            linearity_reg   <= 1'b0;
            low_thresh_reg  <= LOW_THRESH_RST;
            high_thresh_reg <= HIGH_THRESH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_AGC_ENABLE:  agc_enable_reg  <= cfg_data[0];
                REG_LINEARITY:   linearity_reg   <= cfg_data[0];
                REG_LOW_THRESH:  low_thresh_reg  <= cfg_data[THRESH_W-1:0];
                REG_HIGH_THRESH: high_thresh_reg <= cfg_data[THRESH_W-1:0];
                default:         agc_enable_reg  <= agc_enable_reg;
            endcase
        end
    end

    // The compare stage always delivers into the result queue, so a request is
    // taken only when the queue has room for it and for the one in flight.
    assign res_pending = {1'b0, res_level} + (RLVL_W + 1)'(b1_valid_reg);
    assign req_pop     = !req_empty && (res_pending < (RLVL_W + 1)'(RES_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= req_pop;
        end
    end

    // Mean power compare without a divide: (E >> 21) << 24 against thr * n.
    always_ff @(posedge clk)
    begin
        if (req_pop)
        begin
            b1_lhs_reg <= PROD_W'({req_energy[ENERGY_W-1:ENERGY_SHIFT],
                                   {THRESH_FRAC{1'b0}}});
            b1_plo_reg <= PROD_W'(low_thresh_reg) * PROD_W'(req_count);
            b1_phi_reg <= PROD_W'(high_thresh_reg) * PROD_W'(req_count);
            b1_nz_reg  <= (req_count != '0);
        end
    end

    assign below = b1_nz_reg && (b1_lhs_reg < b1_plo_reg);
    assign above = b1_nz_reg && (b1_lhs_reg > b1_phi_reg);

    always_comb
    begin
        step_next = step_reg;
        hold_next = hold_reg;
        act       = ACT_NONE;
        if (agc_enable_reg)
        begin
            priority if (below && hold_reg == '0)
            begin
                if (step_reg < STEP_MAX)
                begin
                    step_next = step_reg + 1'b1;
                end
                hold_next = HOLDOFF_RELOAD;
                act       = ACT_RAISE;
            end
            else if (above && hold_reg == '0)
            begin
                if (step_reg != '0)
                begin
                    step_next = step_reg - 1'b1;
                end
                hold_next = HOLDOFF_RELOAD;
                act       = ACT_LOWER;
            end
            else if (hold_reg != '0)
            begin
                hold_next = hold_reg - 1'b1;
                act       = ACT_HOLD;
            end
            else
            begin
                act       = ACT_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_MAX;
            hold_reg <= '0;
        end
        else if (b1_valid_reg)
        begin
            step_reg <= step_next;
            hold_reg <= hold_next;
        end
    end

    assign res_push               = b1_valid_reg;
    assign res_data.gain_step     = step_next;
    assign res_data.codes         = gain_lookup(step_next, linearity_reg);
    assign res_data.action        = act;
    assign res_data.gain_changed  = (step_next != step_reg);

    `PSAGC_ASSERT_NOW(a_step_bound, 1'b1, step_reg <= STEP_MAX)
    `PSAGC_ASSERT_NOW(a_hold_bound, 1'b1, hold_reg <= HOLDOFF_RELOAD)
    `PSAGC_ASSERT_NOW(a_change_needs_move, res_push && res_data.gain_changed,
        res_data.action == ACT_RAISE || res_data.action == ACT_LOWER)
    `PSAGC_ASSERT_NEXT(a_hold_reload, res_push && res_data.action == ACT_RAISE,
        hold_reg == HOLDOFF_RELOAD)

endmodule

`default_nettype wire

// ===== src/packed_sample_power_agc.sv =====
// ----------------------------------------------------------------------------
// Packed sample power AGC
// Block power detector over packed 12-bit samples with stepped gain control.
// ----------------------------------------------------------------------------
// Input queue side: a transaction moves one 32-bit word (three words carry
// eight samples) when push is high and full is low; last_word ends a transfer.
// One word is taken every cycle while full is low; full rises only when the
// decision queue between the accumulator and the gain logic is out of room.
// Result queue side: a transfer's result waits on the ports while empty is
// low and leaves on a cycle with pop high. Each transfer gives one result.
// Empty falls after the last word passes, in order: it is squared at the edge
// that takes it, the accumulate stage writes the decision queue, the multiply
// stage registers the products, and the decision and table lookup write the
// result queue. Decisions run at one per cycle while it has room.
// When the receiver stalls, results collect in a three-entry result queue,
// then in a four-entry decision queue, after which full holds off new words.
// Configuration: a transaction on cfg_valid/cfg_ready writes register
// cfg_index; cfg_ready is always high. Write it only while the block is idle.
// Reset leaves gain step 21, no holdoff, gain control on, sensitivity tables
// and default thresholds; the sample accumulators and both queues are empty.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_sample_power_agc import psagc_pkg::*;
#(
    parameter int MAX_TRANSFER_SAMPLES = 1048576
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [31:0]            packed_word,
    input  wire logic                   last_word,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [STEP_W-1:0]           gain_step,
    output logic [CODE_W-1:0]           lna_code,
    output logic [CODE_W-1:0]           mixer_code,
    output logic [CODE_W-1:0]           vga_code,
    output logic [1:0]                  action,
    output logic                        gain_changed,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W     = $clog2(MAX_TRANSFER_SAMPLES + 1);
    localparam int ENERGY_W  = CNT_W + SQ_W - 1;
    localparam int REQ_W     = ENERGY_W + CNT_W;
    localparam int Q_DEPTH   = 4;
    localparam int RES_DEPTH = 3;
    localparam int LVL_W     = $clog2(Q_DEPTH + 1);
    localparam int RLVL_W    = $clog2(RES_DEPTH + 1);
    localparam int RES_W     = $bits(result_t);

    logic                req_push;
    logic [ENERGY_W-1:0] front_energy;
    logic [CNT_W-1:0]    front_count;
    logic                req_empty;
    logic                req_pop;
    logic [REQ_W-1:0]    req_data;
    logic [LVL_W-1:0]    q_level;
    logic                res_push;
    result_t             res_in;
    result_t             res_out;
    logic [RLVL_W-1:0]   res_level;

    psagc_front #(
        .MAX_SAMPLES (MAX_TRANSFER_SAMPLES),
        .Q_DEPTH     (Q_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .packed_word (packed_word),
        .last_word   (last_word),
        .q_level     (q_level),
        .req_push    (req_push),
        .req_energy  (front_energy),
        .req_count   (front_count)
    );

    psagc_fifo #(
        .WIDTH (REQ_W),
        .DEPTH (Q_DEPTH)
    ) u_req_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (req_push),
        .wr_data ({front_energy, front_count}),
        .rd_en   (req_pop),
        .empty   (req_empty),
        .rd_data (req_data),
        .level   (q_level)
    );

    psagc_back #(
        .MAX_SAMPLES (MAX_TRANSFER_SAMPLES),
        .RES_DEPTH   (RES_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_empty  (req_empty),
        .req_energy (req_data[REQ_W-1:CNT_W]),
        .req_count  (req_data[CNT_W-1:0]),
        .req_pop    (req_pop),
        .res_level  (res_level),
        .res_push   (res_push),
        .res_data   (res_in)
    );

    psagc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop && !empty),
        .empty   (empty),
        .rd_data (res_out),
        .level   (res_level)
    );

    assign gain_step    = res_out.gain_step;
    assign lna_code     = res_out.codes.lna;
    assign mixer_code   = res_out.codes.mixer;
    assign vga_code     = res_out.codes.vga;
    assign action       = res_out.action;
    assign gain_changed = res_out.gain_changed;

endmodule

`default_nettype wire
